// ===== hdl/rc6_pkg.sv =====
// rc6_pkg: constants, helper functions and control structs shared by the
// RC6 encrypt unit modules. No dependencies.

package rc6_pkg;

    localparam logic [31:0] P32     = 32'hB7E15163;
    localparam logic [31:0] Q32     = 32'h9E3779B9;
    localparam logic [4:0]  LOG_W   = 5'd5;
    localparam logic [4:0]  KEY_ROT = 5'd3;

    localparam int KEY_BITS = 256;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3 = 8'd3;

    localparam logic KIND_EXPAND  = 1'b0;
    localparam logic KIND_ENCRYPT = 1'b1;

    typedef struct packed {
        logic load;
        logic step_a;
        logic step_b;
    } sched_ctl_t;

    typedef struct packed {
        logic load;
        logic whiten_in;
        logic mul;
        logic rnd;
    } round_ctl_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} << n;
        return w[63:32];
    endfunction

    // x * (2x + 1), low word
    function automatic logic [31:0] quad(input logic [31:0] x);
        logic [31:0] m;
        logic [31:0] p;
        m = {x[30:0], 1'b1};
        p = x * m;
        return p;
    endfunction

endpackage

// ===== hdl/rc6_key_store.sv =====
// rc6_key_store: round-key memory, one write port and two registered read
// ports. No dependencies.

module rc6_key_store #(
    parameter int DEPTH = 44,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic [31:0]   rdata0,
    output logic [31:0]   rdata1
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata0_reg;
    logic [31:0] rdata1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ===== hdl/rc6_sched_dp.sv =====
// rc6_sched_dp: key schedule datapath, one mixing step split into an A half
// and a B half, key word scratch and step counters. Depends on rc6_pkg.

module rc6_sched_dp #(
    parameter int STORE_WORDS = 44,
    parameter int KEY_WORDS   = 8,
    parameter int KEY_BYTES   = 32,
    parameter int STEPS       = 132,
    parameter int AW          = 6,
    parameter int SW          = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rc6_pkg::sched_ctl_t       ctl,
    input  logic [rc6_pkg::KEY_BITS-1:0] key_bits,
    input  logic [31:0]               rdata,
    output logic                      we,
    output logic [AW-1:0]             waddr,
    output logic [31:0]               wdata,
    output logic [AW-1:0]             raddr,
    output logic                      last
);

    logic [31:0] a_reg, b_reg, sinit_reg;
    logic [31:0] l_reg [8];
    logic        first_reg;
    logic [AW-1:0] i_reg;
    logic [2:0]    j_reg;
    logic [SW-1:0] s_reg;

    logic [rc6_pkg::KEY_BITS-1:0] key_m;
    logic [31:0] sv, a_next, sum_ab, b_next;
    logic [AW-1:0] i_next;
    logic [2:0]    j_next;
    logic          i_wrap;

    always_comb begin
        for (int n = 0; n < 32; n++) begin
            key_m[8*n +: 8] = (n < KEY_BYTES) ? key_bits[8*n +: 8] : 8'h00;
        end
    end

    assign sv     = first_reg ? sinit_reg : rdata;
    assign a_next = rc6_pkg::rotl32(sv + a_reg + b_reg, rc6_pkg::KEY_ROT);
    assign sum_ab = a_reg + b_reg;
    assign b_next = rc6_pkg::rotl32(l_reg[j_reg] + sum_ab, sum_ab[4:0]);
    assign i_wrap = (i_reg == AW'(STORE_WORDS - 1));
    assign i_next = i_wrap ? '0 : i_reg + 1'b1;
    assign j_next = (j_reg == 3'(KEY_WORDS - 1)) ? 3'd0 : j_reg + 3'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            s_reg     <= '0;
        end else if (ctl.load) begin
            first_reg <= 1'b1;
            i_reg     <= '0;
            j_reg     <= '0;
            s_reg     <= '0;
        end else if (ctl.step_b) begin
            if (i_wrap) begin
                first_reg <= 1'b0;
            end
            i_reg <= i_next;
            j_reg <= j_next;
            s_reg <= s_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            a_reg     <= '0;
            b_reg     <= '0;
            sinit_reg <= rc6_pkg::P32;
            for (int k = 0; k < 8; k++) begin
                l_reg[k] <= key_m[32*k +: 32];
            end
        end else if (ctl.step_a) begin
            a_reg <= a_next;
        end else if (ctl.step_b) begin
            b_reg        <= b_next;
            l_reg[j_reg] <= b_next;
            sinit_reg    <= sinit_reg + rc6_pkg::Q32;
        end
    end

    assign we    = ctl.step_a;
    assign waddr = i_reg;
    assign wdata = a_next;
    assign raddr = i_next;
    assign last  = (s_reg == SW'(STEPS - 1));

endmodule

// ===== hdl/rc6_round_dp.sv =====
// rc6_round_dp: encryption round datapath, multiply step then rotate/add
// step per round, reused for every round. Depends on rc6_pkg.

module rc6_round_dp (
    input  logic               aclk,
    input  rc6_pkg::round_ctl_t ctl,
    input  logic [31:0]        in_a,
    input  logic [31:0]        in_b,
    input  logic [31:0]        in_c,
    input  logic [31:0]        in_d,
    input  logic [31:0]        rdata0,
    input  logic [31:0]        rdata1,
    output logic [31:0]        out_a,
    output logic [31:0]        out_b,
    output logic [31:0]        out_c,
    output logic [31:0]        out_d
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg, t_reg, u_reg;
    logic [31:0] a_next, c_next;

    assign a_next = rc6_pkg::rotl32(a_reg ^ t_reg, u_reg[4:0]) + rdata0;
    assign c_next = rc6_pkg::rotl32(c_reg ^ u_reg, t_reg[4:0]) + rdata1;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            a_reg <= in_a;
            b_reg <= in_b;
            c_reg <= in_c;
            d_reg <= in_d;
        end else if (ctl.whiten_in) begin
            b_reg <= b_reg + rdata0;
            d_reg <= d_reg + rdata1;
        end else if (ctl.mul) begin
            t_reg <= rc6_pkg::rotl32(rc6_pkg::quad(b_reg), rc6_pkg::LOG_W);
            u_reg <= rc6_pkg::rotl32(rc6_pkg::quad(d_reg), rc6_pkg::LOG_W);
        end else if (ctl.rnd) begin
            a_reg <= b_reg;
            b_reg <= c_next;
            c_reg <= d_reg;
            d_reg <= a_next;
        end
    end

    // final whitening folded into the output
    assign out_a = a_reg + rdata0;
    assign out_b = b_reg;
    assign out_c = c_reg + rdata1;
    assign out_d = d_reg;

endmodule

// ===== hdl/rc6_block_encrypt_unit.sv =====
// rc6_block_encrypt_unit: RC6-32/r/b encryption with key schedule, top level.
// Depends on rc6_pkg, rc6_key_store, rc6_sched_dp, rc6_round_dp.
//
// Usage:
//   Write the 256-bit key through the cfg channel (index 0..3, 64 bits each,
//   little-endian bytes) while the block is idle; cfg_ready is always high.
//   Send an item with s_tuser = 0 to run the key schedule: it gives no
//   result and keeps s_tready low until all STEPS mixing steps have run,
//   STEPS = 3*max(key words, 2*ROUNDS+4), each mixing step passing
//   through state ST_XA and then ST_XB.
//   Send an item with s_tuser = 1 and the plaintext on s_tdata to encrypt.
//   The result is loaded into the output register after the input
//   whitening, all ROUNDS rounds and ST_EFIN, and no new item is taken
//   before that; each round spends a state in the squaring multipliers
//   and one in the rotate/add stage.
//   Results sit in an output register; the core accepts and works on the
//   next item while a result waits. An encrypt that finishes while the
//   output register is still full holds until m_tready frees it.
//   Reset clears the key registers and the control; the round-key store
//   holds no valid data until a key schedule has run.

module rc6_block_encrypt_unit #(
    parameter int ROUNDS    = 20,
    parameter int KEY_BYTES = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    // cfg write channel
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [rc6_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]   cfg_data,
    // input items
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // in_a, in_b, in_c, in_d
    input  logic          s_tuser,   // kind
    // result items
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata    // out_a, out_b, out_c, out_d
);

    localparam int STORE_WORDS = 2 * ROUNDS + 4;
    localparam int KEY_WORDS   = (KEY_BYTES + 3) / 4;
    localparam int STEPS       = 3 * ((KEY_WORDS > STORE_WORDS) ? KEY_WORDS : STORE_WORDS);
    localparam int AW          = $clog2(STORE_WORDS);
    localparam int PW          = $clog2(ROUNDS + 2);
    localparam int SW          = $clog2(STEPS);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_XA   = 7'b0000010,
        ST_XB   = 7'b0000100,
        ST_EADD = 7'b0001000,
        ST_EMUL = 7'b0010000,
        ST_ERND = 7'b0100000,
        ST_EFIN = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [PW-1:0] rnd_reg, rnd_next;
    logic [63:0]   key_reg [4];
    logic          m_valid_reg;
    logic [127:0]  m_data_reg;

    logic s_fire, fin_fire, sched_last, sched_we;
    logic [AW-1:0] sched_waddr, sched_raddr, raddr0, raddr1;
    logic [31:0]   sched_wdata, rdata0, rdata1;
    logic [PW-1:0] pair;
    logic [31:0]   res_a, res_b, res_c, res_d;
    rc6_pkg::sched_ctl_t sched_ctl;
    rc6_pkg::round_ctl_t round_ctl;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid & s_tready;
    assign fin_fire  = (state_reg == ST_EFIN) & (!m_valid_reg | m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                key_reg[k] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rc6_pkg::REG_KEY_PART_0: key_reg[0] <= cfg_data;
                rc6_pkg::REG_KEY_PART_1: key_reg[1] <= cfg_data;
                rc6_pkg::REG_KEY_PART_2: key_reg[2] <= cfg_data;
                rc6_pkg::REG_KEY_PART_3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser == rc6_pkg::KIND_EXPAND) ? ST_XA : ST_EADD;
                end
            end
            ST_XA: state_next = ST_XB;
            ST_XB: state_next = sched_last ? ST_IDLE : ST_XA;
            ST_EADD: begin
                state_next = ST_EMUL;
                rnd_next   = PW'(1);
            end
            ST_EMUL: state_next = ST_ERND;
            ST_ERND: begin
                if (rnd_reg == PW'(ROUNDS)) begin
                    state_next = ST_EFIN;
                end else begin
                    state_next = ST_EMUL;
                    rnd_next   = rnd_reg + 1'b1;
                end
            end
            ST_EFIN: begin
                if (fin_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_comb begin
        sched_ctl.load   = s_fire & (s_tuser == rc6_pkg::KIND_EXPAND);
        sched_ctl.step_a = (state_reg == ST_XA);
        sched_ctl.step_b = (state_reg == ST_XB);
        round_ctl.load      = s_fire & (s_tuser == rc6_pkg::KIND_ENCRYPT);
        round_ctl.whiten_in = (state_reg == ST_EADD);
        round_ctl.mul       = (state_reg == ST_EMUL);
        round_ctl.rnd       = (state_reg == ST_ERND);
    end

    // round-key pair address issued in the state before the pair is used
    always_comb begin
        case (state_reg) inside
            ST_EMUL:          pair = rnd_reg;
            ST_ERND, ST_EFIN: pair = rnd_reg + 1'b1;
            default:          pair = '0;
        endcase
        raddr0 = {pair, 1'b0};
        raddr1 = {pair, 1'b1};
        if (state_reg == ST_XA || state_reg == ST_XB) begin
            raddr0 = sched_raddr;
        end
    end

    rc6_key_store #(
        .DEPTH(STORE_WORDS),
        .AW   (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (sched_we),
        .waddr (sched_waddr),
        .wdata (sched_wdata),
        .raddr0(raddr0),
        .raddr1(raddr1),
        .rdata0(rdata0),
        .rdata1(rdata1)
    );

    rc6_sched_dp #(
        .STORE_WORDS(STORE_WORDS),
        .KEY_WORDS  (KEY_WORDS),
        .KEY_BYTES  (KEY_BYTES),
        .STEPS      (STEPS),
        .AW         (AW),
        .SW         (SW)
    ) u_sched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (sched_ctl),
        .key_bits({key_reg[3], key_reg[2], key_reg[1], key_reg[0]}),
        .rdata   (rdata0),
        .we      (sched_we),
        .waddr   (sched_waddr),
        .wdata   (sched_wdata),
        .raddr   (sched_raddr),
        .last    (sched_last)
    );

    rc6_round_dp u_round (
        .aclk  (aclk),
        .ctl   (round_ctl),
        .in_a  (s_tdata[31:0]),
        .in_b  (s_tdata[63:32]),
        .in_c  (s_tdata[95:64]),
        .in_d  (s_tdata[127:96]),
        .rdata0(rdata0),
        .rdata1(rdata1),
        .out_a (res_a),
        .out_b (res_b),
        .out_c (res_c),
        .out_d (res_d)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_fire) begin
            m_data_reg <= {res_d, res_c, res_b, res_a};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
